FILE: design/lef_pkg.sv
// Shared types and constants of the 3x3 Laplacian edge filter.
`timescale 1ns / 1ps

package lef_pkg;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE    = 2'd2;

  // Register widths and reset values.
  localparam int unsigned WIDTH_REG_BITS  = 10;
  localparam int unsigned HEIGHT_REG_BITS = 13;
  localparam int unsigned MAXV_BITS       = 16;
  localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [HEIGHT_REG_BITS-1:0] IMAGE_HEIGHT_RST = 13'd512;
  localparam logic [MAXV_BITS-1:0]       MAX_VALUE_RST    = 16'd255;

  // Largest frame height that the row counter supports.
  localparam logic [HEIGHT_REG_BITS-1:0] MAX_ROWS = 13'd4096;

  // Result fields.
  localparam int unsigned PIX_OUT_BITS = 16;
  localparam int unsigned ROW_BITS     = 12;
  localparam int unsigned COL_BITS     = 9;

  // Each input pixel produces at most this many results.
  localparam int unsigned RES_LANES = 3;

  // Result queue depth; must be a power of two.
  localparam int unsigned FIFO_DEPTH = 8;

  // One result item.
  typedef struct packed {
    logic [PIX_OUT_BITS-1:0] pixel;
    logic [ROW_BITS-1:0]     row;
    logic [COL_BITS-1:0]     col;
    logic                    last;
  } res_t;

  // Position flags of a pixel, worked out when it is accepted.
  typedef struct packed {
    logic prev_row;  // row index is at least one
    logic prev_col;  // column index is at least one
    logic row_end;   // last column of the row
    logic last_row;  // last row of the frame
    logic interior;  // the left-upper neighbor result is a filtered pixel
  } pos_flags_t;

endpackage

FILE: design/lef_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module lef_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; a read of the same address returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lef_kernel.sv
// Laplacian kernel sum with clamping for one window position.
`timescale 1ns / 1ps

module lef_kernel import lef_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic [PIXEL_BITS-1:0]   win_i [6],
  input  logic [PIXEL_BITS-1:0]   up_i,
  input  logic [PIXEL_BITS-1:0]   mid_i,
  input  logic [PIXEL_BITS-1:0]   pix_i,
  input  logic [MAXV_BITS-1:0]    max_value_i,
  input  logic                    interior_i,
  output logic [PIX_OUT_BITS-1:0] value_o
);

  // Wide enough for 20 times a full-scale pixel and for the clamp limit.
  localparam int unsigned SW = (PIXEL_BITS + 7 > 17) ? PIXEL_BITS + 7 : 17;

  logic signed [SW-1:0] centre20;
  logic signed [SW-1:0] edges;
  logic signed [SW-1:0] corners;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] limit;

  // Centre is win[3]; edges are above, left, right and below; the rest are corners.
  always_comb begin
    centre20 = (SW'(win_i[3]) << 4) + (SW'(win_i[3]) << 2);
    edges    = SW'(win_i[1]) + SW'(win_i[2]) + SW'(mid_i) + SW'(win_i[5]);
    corners  = SW'(win_i[0]) + SW'(up_i) + SW'(win_i[4]) + SW'(pix_i);
    sum      = centre20 - (edges << 2) - corners;
    limit    = SW'(max_value_i);
  end

  // Clamp interior results; other positions pass the centre pixel unchanged.
  always_comb begin
    if (!interior_i) begin
      value_o = PIX_OUT_BITS'(win_i[3]);
    end else if (sum[SW-1]) begin
      value_o = '0;
    end else if (sum > limit) begin
      value_o = max_value_i;
    end else begin
      value_o = PIX_OUT_BITS'(sum);
    end
  end

endmodule

FILE: design/lef_fifo.sv
// Result queue that takes up to three results per cycle and returns one.
`timescale 1ns / 1ps

module lef_fifo import lef_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i [RES_LANES],
  input  res_t                       push_data_i  [RES_LANES],
  input  logic                       pop_i,
  output res_t                       head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    off1, off2, npush;

  // Pack the valid lanes into consecutive slots after the tail.
  always_comb begin
    off1    = {1'b0, push_valid_i[0]};
    off2    = off1 + {1'b0, push_valid_i[1]};
    npush   = off2 + {1'b0, push_valid_i[2]};
    tail_d  = tail_q + PW'(npush);
    head_d  = pop_i ? head_q + PW'(1) : head_q;
    count_d = count_q + CW'(npush) - CW'(pop_i);
  end

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_valid_i[0]) begin
      mem_q[tail_q] <= push_data_i[0];
    end
    if (push_valid_i[1]) begin
      mem_q[tail_q + PW'(off1)] <= push_data_i[1];
    end
    if (push_valid_i[2]) begin
      mem_q[tail_q + PW'(off2)] <= push_data_i[2];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_o  = mem_q[head_q];
  assign count_o = count_q;

endmodule

FILE: design/laplacian_edge_filter_3x3_unit.sv
// Top level of the streaming 3x3 Laplacian edge filter.
`timescale 1ns / 1ps

// Pixels enter in raster order, one request per cycle unless the input
// stalls, and results leave through an eight-entry result queue. A pixel
// yields up to three results: the pixel up and to the left, plus the pixel
// above at the end of a row, plus itself in the last row. Results leave at
// one per cycle unless the output stalls. Outside the last row a frame
// yields one result per pixel on average, and the extra result at a row end
// is absorbed by the queue, so the input runs at one pixel per cycle. In the
// last row each pixel yields one to three results and the output port sets
// the pace, as it does whenever the output stalls. The input stalls whenever
// the queue could not hold the results of the pixel in flight and of a new
// one. The two line buffers are RAMs with no clearing pass after reset: the
// first two rows of a frame write them before their data reaches a result.
// Configuration registers (width, height, clamp limit) sit at byte addresses
// 0, 4 and 8 and should be written between requests.
module laplacian_edge_filter_3x3_unit import lef_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Pixel input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             pixel_in_i,
  // Result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PIX_OUT_BITS-1:0] pixel_out_o,
  output logic [ROW_BITS-1:0]     out_row_o,
  output logic [COL_BITS-1:0]     out_col_o,
  output logic                    frame_last_o
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = AW + 1;
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  logic [WIDTH_REG_BITS-1:0]  img_width_q;
  logic [HEIGHT_REG_BITS-1:0] img_height_q;
  logic [MAXV_BITS-1:0]       max_value_q;
  logic                       cfg_write;

  // Position counters and effective frame size
  logic [AW-1:0]              col_cnt_q;
  logic [ROW_BITS-1:0]        row_cnt_q;
  logic [WW-1:0]              width_eff;
  logic [HEIGHT_REG_BITS-1:0] height_eff;
  pos_flags_t                 flags;
  logic                       accept;

  // Second stage
  logic                       s1_valid_q;
  logic [PIXEL_BITS-1:0]      s1_pix_q;
  logic [ROW_BITS-1:0]        s1_row_q;
  logic [AW-1:0]              s1_col_q;
  pos_flags_t                 s1_flags_q;
  logic [PIXEL_BITS-1:0]      win_q [6];
  logic [PIXEL_BITS-1:0]      up_rdata, mid_rdata, up, mid;
  logic                       byp_q;
  logic [PIXEL_BITS-1:0]      byp_up_q, byp_mid_q;
  logic [PIX_OUT_BITS-1:0]    filt_value;

  // Result queue
  logic                       push_valid [RES_LANES];
  res_t                       push_data  [RES_LANES];
  res_t                       head;
  logic [FCW-1:0]             fifo_count;
  logic [FCW:0]               fifo_need;
  logic                       pop;

  // Configuration writes and reads.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= IMAGE_WIDTH_RST;
      img_height_q <= IMAGE_HEIGHT_RST;
      max_value_q  <= MAX_VALUE_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  img_width_q  <= pwdata[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT: img_height_q <= pwdata[HEIGHT_REG_BITS-1:0];
        REG_MAX_VALUE:    max_value_q  <= pwdata[MAXV_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = 32'(img_width_q);
      REG_IMAGE_HEIGHT: prdata = 32'(img_height_q);
      REG_MAX_VALUE:    prdata = 32'(max_value_q);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (img_width_q == '0) begin
      width_eff = WW'(1);
    end else if (32'(img_width_q) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(img_width_q);
    end
    if (img_height_q == '0) begin
      height_eff = HEIGHT_REG_BITS'(1);
    end else if (img_height_q > MAX_ROWS) begin
      height_eff = MAX_ROWS;
    end else begin
      height_eff = img_height_q;
    end
  end

  // Position flags of the pixel at the input.
  always_comb begin
    flags.prev_row = (row_cnt_q != '0);
    flags.prev_col = (col_cnt_q != '0);
    flags.row_end  = ({1'b0, col_cnt_q} + WW'(1)) >= width_eff;
    flags.last_row = ({1'b0, row_cnt_q} + HEIGHT_REG_BITS'(1)) >= height_eff;
    flags.interior = (row_cnt_q >= ROW_BITS'(2)) && ({1'b0, row_cnt_q} < height_eff)
                     && (col_cnt_q >= AW'(2)) && ({1'b0, col_cnt_q} < width_eff);
  end

  // Input handshake; leave room for the results of the staged pixel, if any, and the new one.
  assign fifo_need  = {1'b0, fifo_count} + (s1_valid_q ? (FCW + 1)'(2 * RES_LANES)
                                                       : (FCW + 1)'(RES_LANES));
  assign in_stall_o = fifo_need > (FCW + 1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // Raster counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (flags.row_end) begin
        col_cnt_q <= '0;
        row_cnt_q <= flags.last_row ? '0 : row_cnt_q + ROW_BITS'(1);
      end else begin
        col_cnt_q <= col_cnt_q + AW'(1);
      end
    end
  end

  // Input register of the second stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      byp_q      <= accept && s1_valid_q && (col_cnt_q == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_in_i[PIXEL_BITS-1:0];
      s1_row_q   <= row_cnt_q;
      s1_col_q   <= col_cnt_q;
      s1_flags_q <= flags;
      byp_up_q   <= mid;
      byp_mid_q  <= s1_pix_q;
    end
  end

  // Line buffers: read at acceptance, written back by the second stage.
  lef_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid),
    .re_i    (accept),
    .raddr_i (col_cnt_q),
    .rdata_o (up_rdata)
  );

  lef_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (col_cnt_q),
    .rdata_o (mid_rdata)
  );

  // A read that met a write to the same column takes the written data.
  assign up  = byp_q ? byp_up_q  : up_rdata;
  assign mid = byp_q ? byp_mid_q : mid_rdata;

  // Sliding window over the two previous columns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= up;
      win_q[2] <= win_q[3];
      win_q[3] <= mid;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_pix_q;
    end
  end

  lef_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .win_i       (win_q),
    .up_i        (up),
    .mid_i       (mid),
    .pix_i       (s1_pix_q),
    .max_value_i (max_value_q),
    .interior_i  (s1_flags_q.interior),
    .value_o     (filt_value)
  );

  // Results of the pixel in the second stage, in emission order.
  always_comb begin
    push_valid[0]      = s1_valid_q && s1_flags_q.prev_row && s1_flags_q.prev_col;
    push_data[0].pixel = filt_value;
    push_data[0].row   = s1_row_q - ROW_BITS'(1);
    push_data[0].col   = COL_BITS'(s1_col_q - AW'(1));
    push_data[0].last  = 1'b0;

    push_valid[1]      = s1_valid_q && s1_flags_q.prev_row && s1_flags_q.row_end;
    push_data[1].pixel = PIX_OUT_BITS'(mid);
    push_data[1].row   = s1_row_q - ROW_BITS'(1);
    push_data[1].col   = COL_BITS'(s1_col_q);
    push_data[1].last  = 1'b0;

    push_valid[2]      = s1_valid_q && s1_flags_q.last_row;
    push_data[2].pixel = PIX_OUT_BITS'(s1_pix_q);
    push_data[2].row   = s1_row_q;
    push_data[2].col   = COL_BITS'(s1_col_q);
    push_data[2].last  = s1_flags_q.row_end;
  end

  lef_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_o       (head),
    .count_o      (fifo_count)
  );

  // Output channel straight from the queue head.
  assign out_valid_o  = (fifo_count != '0);
  assign pop          = out_valid_o && !out_stall_i;
  assign pixel_out_o  = head.pixel;
  assign out_row_o    = head.row;
  assign out_col_o    = head.col;
  assign frame_last_o = head.last;

endmodule

FILE: design/lef_checker.sv
// Port-level checks of the Laplacian edge filter, bound to its top level.
`timescale 1ns / 1ps

module lef_checker import lef_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [PIX_OUT_BITS-1:0] pixel_out_o,
  input logic [ROW_BITS-1:0]     out_row_o,
  input logic [COL_BITS-1:0]     out_col_o,
  input logic                    frame_last_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_out_o) && $stable(out_row_o)
                                   && $stable(out_col_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  // The input only stalls while results are waiting to leave.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result queue");

  // A result appearing from an empty queue comes from an accepted pixel.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching request");

endmodule

bind laplacian_edge_filter_3x3_unit lef_checker u_lef_checker (.*);
